// ===== sv/mooc_pkg.sv =====
// ----------------------------------------------------------------------------
// mooc_pkg
// Shared types and constants of the median obstacle override block.
// ----------------------------------------------------------------------------
package mooc_pkg;

  localparam int WINDOW      = 5;
  localparam int IDX_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int MEDIAN_RANK = WINDOW / 2;

  localparam int RAW_W  = 16;
  localparam int TIME_W = 32;
  localparam int DIST_W = 9;
  localparam int CMD_W  = 12;
  localparam int DLY_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(500);
  localparam logic [RAW_W-1:0]  DIST_MIN = RAW_W'(2);
  localparam logic [CMD_W-1:0]  CMD_MAX  = {CMD_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_THRESHOLD   = 3'd0,
    CFG_CENTER_CMD       = 3'd1,
    CFG_AVOID_OFFSET     = 3'd2,
    CFG_SLOW_THROTTLE    = 3'd3,
    CFG_NEUTRAL_THROTTLE = 3'd4,
    CFG_EXIT_DELAY_MS    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DIST_W-1:0] stop_threshold;
    logic [CMD_W-1:0]  center_cmd;
    logic [CMD_W-1:0]  avoid_offset;
    logic [CMD_W-1:0]  slow_throttle;
    logic [CMD_W-1:0]  neutral_throttle;
    logic [DLY_W-1:0]  exit_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic rotate;
  } cell_ctl_t;

  typedef struct packed {
    logic [DIST_W-1:0] filtered_distance;
    logic              override_active;
    logic [CMD_W-1:0]  steer_command;
    logic [CMD_W-1:0]  throttle_command;
    logic              resume_pulse;
  } res_t;

endpackage

// ===== sv/mooc_if.sv =====
// ----------------------------------------------------------------------------
// mooc_in_if / mooc_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface mooc_in_if import mooc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_distance;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, raw_distance, now_ms, input ready);
  modport sink (input valid, raw_distance, now_ms, output ready);
endinterface

interface mooc_out_if import mooc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] filtered_distance;
  logic              override_active;
  logic [CMD_W-1:0]  steer_command;
  logic [CMD_W-1:0]  throttle_command;
  logic              resume_pulse;

  modport source (output valid, filtered_distance, override_active, steer_command,
                  throttle_command, resume_pulse, input ready);
  modport sink (input valid, filtered_distance, override_active, steer_command,
                throttle_command, resume_pulse, output ready);
endinterface

// ===== sv/mooc_cell.sv =====
// ----------------------------------------------------------------------------
// mooc_cell
// One window entry: holds a sample, passes it down the shift line, and ranks
// it against the probes that circulate around the ring of cells.
// ----------------------------------------------------------------------------
module mooc_cell import mooc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic [IDX_W-1:0]  my_idx,
  input  logic [DIST_W-1:0] shift_in,
  input  logic [DIST_W-1:0] probe_in,
  input  logic [IDX_W-1:0]  probe_idx_in,
  output logic [DIST_W-1:0] value,
  output logic [DIST_W-1:0] probe,
  output logic [IDX_W-1:0]  probe_idx,
  output logic [CNT_W-1:0]  rank
);

  logic [DIST_W-1:0] value_r, value_nxt;
  logic [DIST_W-1:0] probe_r, probe_nxt;
  logic [IDX_W-1:0]  probe_idx_r, probe_idx_nxt;
  logic [CNT_W-1:0]  rank_r, rank_nxt;
  logic              below;

  // ties broken by cell position so every rank is unique
  assign below = (probe_r < value_r) || ((probe_r == value_r) && (probe_idx_r < my_idx));

  always_comb begin
    value_nxt     = ctl.shift ? shift_in : value_r;
    probe_nxt     = probe_r;
    probe_idx_nxt = probe_idx_r;
    rank_nxt      = rank_r;
    if (ctl.load) begin
      probe_nxt     = value_nxt;
      probe_idx_nxt = my_idx;
      rank_nxt      = '0;
    end else if (ctl.rotate) begin
      probe_nxt     = probe_in;
      probe_idx_nxt = probe_idx_in;
      rank_nxt      = rank_r + CNT_W'(below);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= DIST_MAX;
    end else begin
      value_r <= value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r     <= probe_nxt;
    probe_idx_r <= probe_idx_nxt;
    rank_r      <= rank_nxt;
  end

  assign value     = value_r;
  assign probe     = probe_r;
  assign probe_idx = probe_idx_r;
  assign rank      = rank_r;

endmodule

// ===== sv/mooc_override.sv =====
// ----------------------------------------------------------------------------
// mooc_override
// Obstacle override state: entry with alternating turn side, exit timer and
// resume pulse, plus the steering and throttle commands.
// ----------------------------------------------------------------------------
module mooc_override import mooc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              commit,
  input  logic [DIST_W-1:0] median,
  input  logic [TIME_W-1:0] now_ms,
  input  cfg_t              cfg,
  output res_t              res
);

  logic              turn_left_r, turn_left_nxt;
  logic              active_r, active_nxt;
  logic              timing_r, timing_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic              resume;
  logic [TIME_W-1:0] elapsed;
  logic [CMD_W:0]    steer_sum;
  logic [CMD_W-1:0]  steer_avoid;

  always_comb begin
    turn_left_nxt = turn_left_r;
    active_nxt    = active_r;
    timing_nxt    = timing_r;
    start_nxt     = start_r;
    resume        = 1'b0;
    elapsed       = '0;
    if (median < cfg.stop_threshold) begin
      if (!active_r) begin
        turn_left_nxt = ~turn_left_r;
      end
      timing_nxt = 1'b0;
      active_nxt = 1'b1;
    end else begin
      if (active_r && !timing_r) begin
        start_nxt  = now_ms;
        timing_nxt = 1'b1;
      end
      elapsed = now_ms - start_nxt;
      if (timing_nxt && (elapsed > TIME_W'(cfg.exit_delay_ms))) begin
        active_nxt = 1'b0;
        timing_nxt = 1'b0;
        resume     = 1'b1;
      end
    end
  end

  assign steer_sum = {1'b0, cfg.center_cmd} + {1'b0, cfg.avoid_offset};

  always_comb begin
    if (turn_left_nxt) begin
      steer_avoid = (cfg.avoid_offset > cfg.center_cmd) ? '0
                  : cfg.center_cmd - cfg.avoid_offset;
    end else begin
      steer_avoid = steer_sum[CMD_W] ? CMD_MAX : steer_sum[CMD_W-1:0];
    end
  end

  always_comb begin
    res.filtered_distance = median;
    res.override_active   = active_nxt;
    res.steer_command     = active_nxt ? steer_avoid : cfg.center_cmd;
    res.throttle_command  = active_nxt ? cfg.slow_throttle : cfg.neutral_throttle;
    res.resume_pulse      = resume;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_left_r <= 1'b0;
      active_r    <= 1'b0;
      timing_r    <= 1'b0;
      start_r     <= '0;
    end else if (commit) begin
      turn_left_r <= turn_left_nxt;
      active_r    <= active_nxt;
      timing_r    <= timing_nxt;
      start_r     <= start_nxt;
    end
  end

endmodule

// ===== sv/median_obstacle_override_core.sv =====
// A sample is taken in ST_IDLE and ranked in ST_CMP, one probe step per cycle around
// the ring of WINDOW cells; ST_DONE commits the result once the output register is free.
//   No new sample is taken before that commit.
// A result may wait in the output register while the next sample is taken.
// Reset (synchronous, rst_n low): window entries 500, override idle, configuration
//   at its defaults; no clearing pass.
// ----------------------------------------------------------------------------
// median_obstacle_override_core
// Running median over a window of range samples driving an obstacle override.
// ----------------------------------------------------------------------------
module median_obstacle_override_core import mooc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mooc_in_if.sink               in_chan,
  mooc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] now_r;
  cfg_t              cfg_r;
  res_t              res_r, res_c;
  logic              out_valid_r, out_valid_nxt;
  logic              in_xfer, commit;
  cell_ctl_t         ctl;
  logic [DIST_W-1:0] sample;
  logic [DIST_W-1:0] median;

  logic [DIST_W-1:0] value   [WINDOW];
  logic [DIST_W-1:0] probe   [WINDOW];
  logic [IDX_W-1:0]  probe_i [WINDOW];
  logic [CNT_W-1:0]  rank    [WINDOW];

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;

  // out of range readings count as far away
  assign sample = ((in_chan.raw_distance < DIST_MIN) ||
                   (in_chan.raw_distance > RAW_W'(DIST_MAX)))
                  ? DIST_MAX : in_chan.raw_distance[DIST_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ctl           = '0;
    commit        = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ctl.shift = 1'b1;
          ctl.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.rotate = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(WINDOW - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          commit        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    localparam int NB = (i + 1) % WINDOW;
    logic [DIST_W-1:0] shift_in;
    if (i == 0) begin : g_head
      assign shift_in = sample;
    end else begin : g_body
      assign shift_in = value[i-1];
    end
    mooc_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .my_idx       (IDX_W'(i)),
      .shift_in     (shift_in),
      .probe_in     (probe[NB]),
      .probe_idx_in (probe_i[NB]),
      .value        (value[i]),
      .probe        (probe[i]),
      .probe_idx    (probe_i[i]),
      .rank         (rank[i])
    );
  end

  // exactly one cell holds the middle rank
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == CNT_W'(MEDIAN_RANK)) begin
        median = median | value[i];
      end
    end
  end

  mooc_override u_override (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .median (median),
    .now_ms (now_r),
    .cfg    (cfg_r),
    .res    (res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r <= in_chan.now_ms;
    end
    if (commit) begin
      res_r <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_threshold   <= DIST_W'(50);
      cfg_r.center_cmd       <= CMD_W'(90);
      cfg_r.avoid_offset     <= CMD_W'(30);
      cfg_r.slow_throttle    <= CMD_W'(100);
      cfg_r.neutral_throttle <= CMD_W'(90);
      cfg_r.exit_delay_ms    <= DLY_W'(150);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_STOP_THRESHOLD:   cfg_r.stop_threshold   <= cfg_data[DIST_W-1:0];
        CFG_CENTER_CMD:       cfg_r.center_cmd       <= cfg_data[CMD_W-1:0];
        CFG_AVOID_OFFSET:     cfg_r.avoid_offset     <= cfg_data[CMD_W-1:0];
        CFG_SLOW_THROTTLE:    cfg_r.slow_throttle    <= cfg_data[CMD_W-1:0];
        CFG_NEUTRAL_THROTTLE: cfg_r.neutral_throttle <= cfg_data[CMD_W-1:0];
        CFG_EXIT_DELAY_MS:    cfg_r.exit_delay_ms    <= cfg_data[DLY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.filtered_distance = res_r.filtered_distance;
  assign out_chan.override_active   = res_r.override_active;
  assign out_chan.steer_command     = res_r.steer_command;
  assign out_chan.throttle_command  = res_r.throttle_command;
  assign out_chan.resume_pulse      = res_r.resume_pulse;

endmodule
